// File: design/vtf_pkg.sv
`timescale 1ns / 1ps

package vtf_pkg;

  // Fixed point and timing constants.
  localparam int GAIN_FRAC_BITS   = 12;
  localparam int LOST_HOVER_TICKS = 20;

  // Widths of the internal position, product and counter values.
  localparam int POS_W  = 18;
  localparam int SUM_W  = POS_W + 1;
  localparam int PROD_W = SUM_W + 16;
  localparam int LOST_W = 5;
  localparam int RUN_W  = 8;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_GAIN_X        = 3'd0,
    CFG_GAIN_Y        = 3'd1,
    CFG_GAIN_Z        = 3'd2,
    CFG_OFFSET_X      = 3'd3,
    CFG_OFFSET_Y      = 3'd4,
    CFG_OFFSET_Z      = 3'd5,
    CFG_HOLD_HEIGHT   = 3'd6,
    CFG_RUN_THRESHOLD = 3'd7
  } vtf_cfg_idx_e;

  // Command codes carried in the result word.
  typedef enum logic [1:0] {
    CMD_HOVER_INIT = 2'd0,
    CMD_MOVE       = 2'd1,
    CMD_HOVER_HERE = 2'd2
  } vtf_cmd_e;

  // Input word kinds.
  localparam logic FUNC_DETECT = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  // Mode machine, one-hot.
  typedef enum logic [2:0] {
    PH_WAIT  = 3'b001,
    PH_TRACK = 3'b010,
    PH_LOST  = 3'b100
  } vtf_phase_e;

  typedef struct packed {
    logic               func;
    logic               has_target;
    logic signed [15:0] cam_right;
    logic signed [15:0] cam_down;
    logic signed [15:0] cam_ahead;
    logic        [15:0] confidence;
    logic               selected;
    logic               command_mode_on;
  } vtf_in_t;

  typedef struct packed {
    logic        [1:0]  command;
    logic signed [15:0] vel_forward;
    logic signed [15:0] vel_left;
    logic signed [15:0] vel_up;
    logic        [31:0] command_number;
  } vtf_out_t;

  typedef struct packed {
    logic        [15:0] gain_x;
    logic        [15:0] gain_y;
    logic        [15:0] gain_z;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] offset_z;
    logic signed [15:0] hold_height;
    logic        [RUN_W-1:0] run_threshold;
  } vtf_cfg_t;

  // Proportional velocity: round(gain * pos / 2^F), ties away from zero,
  // saturated to the signed 16-bit range.
  function automatic logic signed [15:0] scale_vel(input logic signed [SUM_W-1:0] pos,
                                                   input logic [15:0] gain);
    logic [SUM_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] rnd;
    mag  = pos[SUM_W-1] ? SUM_W'(-pos) : SUM_W'(pos);
    prod = PROD_W'(mag) * PROD_W'(gain);
    rnd  = (prod + (PROD_W'(1) << (GAIN_FRAC_BITS - 1))) >> GAIN_FRAC_BITS;
    if (pos[SUM_W-1]) begin
      scale_vel = (rnd > PROD_W'(32768)) ? 16'sh8000 : -$signed(rnd[15:0]);
    end else begin
      scale_vel = (rnd > PROD_W'(32767)) ? 16'sh7fff : $signed(rnd[15:0]);
    end
  endfunction

endpackage

// File: design/vtf_cfg_regs.sv
`timescale 1ns / 1ps

module vtf_cfg_regs import vtf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output vtf_cfg_t    cfg_o
);

  vtf_cfg_t cfg_q;

  // Register file with its reset values; one register written per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_x        <= 16'd2458;
      cfg_q.gain_y        <= 16'd2458;
      cfg_q.gain_z        <= 16'd1229;
      cfg_q.offset_x      <= 16'sd0;
      cfg_q.offset_y      <= 16'sd0;
      cfg_q.offset_z      <= 16'sd0;
      cfg_q.hold_height   <= 16'sd1500;
      cfg_q.run_threshold <= RUN_W'(10);
    end else if (cfg_we_i) begin
      unique case (vtf_cfg_idx_e'(cfg_index_i))
        CFG_GAIN_X:        cfg_q.gain_x        <= cfg_data_i;
        CFG_GAIN_Y:        cfg_q.gain_y        <= cfg_data_i;
        CFG_GAIN_Z:        cfg_q.gain_z        <= cfg_data_i;
        CFG_OFFSET_X:      cfg_q.offset_x      <= $signed(cfg_data_i);
        CFG_OFFSET_Y:      cfg_q.offset_y      <= $signed(cfg_data_i);
        CFG_OFFSET_Z:      cfg_q.offset_z      <= $signed(cfg_data_i);
        CFG_HOLD_HEIGHT:   cfg_q.hold_height   <= $signed(cfg_data_i);
        CFG_RUN_THRESHOLD: cfg_q.run_threshold <= cfg_data_i[RUN_W-1:0];
        default:           cfg_q.gain_x        <= cfg_q.gain_x;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/vtf_core.sv
`timescale 1ns / 1ps

module vtf_core import vtf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  vtf_cfg_t cfg_i,
  input  logic     item_valid_i,
  input  vtf_in_t  item_i,
  output logic     item_take_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output vtf_out_t out_data_o
);

  // Tracking state.
  vtf_phase_e              phase_q, phase_d;
  logic signed [POS_W-1:0] pos_fwd_q, pos_fwd_d;
  logic signed [POS_W-1:0] pos_left_q, pos_left_d;
  logic signed [POS_W-1:0] pos_up_q, pos_up_d;
  logic                    conf_hit_q, conf_hit_d;
  logic                    sel_q, sel_d;
  logic [RUN_W-1:0]        hit_run_q, hit_run_d;
  logic [RUN_W-1:0]        miss_run_q, miss_run_d;
  logic                    seen_q, seen_d;
  logic [LOST_W-1:0]       lost_q, lost_d;
  vtf_cmd_e                held_cmd_q, held_cmd_d;
  logic signed [15:0]      vel_fwd_q, vel_fwd_d;
  logic signed [15:0]      vel_left_q, vel_left_d;
  logic signed [15:0]      vel_up_q, vel_up_d;
  logic [31:0]             seq_q, seq_d;

  // Result register.
  logic     out_valid_q, out_valid_d;
  vtf_out_t out_q, out_d;

  logic                    gives_result;
  logic                    out_free;
  logic                    take;
  logic                    hit_eff;
  logic [LOST_W-1:0]       lost_inc;
  logic signed [SUM_W-1:0] up_sum;

  assign gives_result = (item_i.func == FUNC_TICK) && item_i.command_mode_on;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign take         = item_valid_i && (!gives_result || out_free);
  assign item_take_o  = take;

  assign hit_eff  = item_i.has_target ? (item_i.confidence != 16'd0) : conf_hit_q;
  assign lost_inc = (lost_q == '1) ? lost_q : lost_q + LOST_W'(1);
  assign up_sum   = SUM_W'(pos_up_q) + SUM_W'(cfg_i.hold_height);

  // Detection update and mode machine step for the word in the input register.
  always_comb begin
    phase_d    = phase_q;
    pos_fwd_d  = pos_fwd_q;
    pos_left_d = pos_left_q;
    pos_up_d   = pos_up_q;
    conf_hit_d = conf_hit_q;
    sel_d      = sel_q;
    hit_run_d  = hit_run_q;
    miss_run_d = miss_run_q;
    seen_d     = seen_q;
    lost_d     = lost_q;
    held_cmd_d = held_cmd_q;
    vel_fwd_d  = vel_fwd_q;
    vel_left_d = vel_left_q;
    vel_up_d   = vel_up_q;
    seq_d      = seq_q;

    if (take && item_i.func == FUNC_DETECT) begin
      // Camera axes are negated into the body frame, then offset.
      if (item_i.has_target) begin
        pos_fwd_d  = -POS_W'(item_i.cam_down) + POS_W'(cfg_i.offset_x);
        pos_left_d = -POS_W'(item_i.cam_right) + POS_W'(cfg_i.offset_y);
        pos_up_d   = -POS_W'(item_i.cam_ahead) + POS_W'(cfg_i.offset_z);
        sel_d      = item_i.selected;
      end
      conf_hit_d = hit_eff;
      if (hit_eff) begin
        miss_run_d = '0;
        hit_run_d  = (hit_run_q == '1) ? hit_run_q : hit_run_q + RUN_W'(1);
      end else begin
        hit_run_d  = '0;
        miss_run_d = (miss_run_q == '1) ? miss_run_q : miss_run_q + RUN_W'(1);
      end
      if (miss_run_d > cfg_i.run_threshold) begin
        seen_d = 1'b0;
      end
      if (hit_run_d > cfg_i.run_threshold) begin
        seen_d = 1'b1;
      end
    end else if (take && gives_result) begin
      unique case (phase_q)
        PH_TRACK: begin
          if (!sel_q || !seen_q) begin
            phase_d = PH_LOST;
            lost_d  = '0;
          end else begin
            held_cmd_d = CMD_MOVE;
            vel_fwd_d  = scale_vel(SUM_W'(pos_fwd_q), cfg_i.gain_x);
            vel_left_d = scale_vel(SUM_W'(pos_left_q), cfg_i.gain_y);
            vel_up_d   = scale_vel(up_sum, cfg_i.gain_z);
          end
        end
        PH_LOST: begin
          lost_d     = lost_inc;
          held_cmd_d = (lost_inc < LOST_W'(LOST_HOVER_TICKS)) ? CMD_HOVER_HERE
                                                              : CMD_HOVER_INIT;
          if (sel_q) begin
            phase_d = PH_TRACK;
          end
        end
        default: begin
          if (sel_q && seen_q) begin
            phase_d = PH_TRACK;
          end else begin
            held_cmd_d = CMD_HOVER_INIT;
          end
        end
      endcase
      seq_d = seq_q + 32'd1;
    end
  end

  // Result word loads when a tick in command mode is taken; it drains when the receiver takes it.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (take && gives_result) begin
      out_valid_d          = 1'b1;
      out_d.command        = held_cmd_d;
      out_d.vel_forward    = vel_fwd_d;
      out_d.vel_left       = vel_left_d;
      out_d.vel_up         = vel_up_d;
      out_d.command_number = seq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT;
      pos_fwd_q   <= '0;
      pos_left_q  <= '0;
      pos_up_q    <= '0;
      conf_hit_q  <= 1'b0;
      sel_q       <= 1'b0;
      hit_run_q   <= '0;
      miss_run_q  <= '0;
      seen_q      <= 1'b0;
      lost_q      <= '0;
      held_cmd_q  <= CMD_HOVER_INIT;
      vel_fwd_q   <= '0;
      vel_left_q  <= '0;
      vel_up_q    <= '0;
      seq_q       <= 32'd1;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pos_fwd_q   <= pos_fwd_d;
      pos_left_q  <= pos_left_d;
      pos_up_q    <= pos_up_d;
      conf_hit_q  <= conf_hit_d;
      sel_q       <= sel_d;
      hit_run_q   <= hit_run_d;
      miss_run_q  <= miss_run_d;
      seen_q      <= seen_d;
      lost_q      <= lost_d;
      held_cmd_q  <= held_cmd_d;
      vel_fwd_q   <= vel_fwd_d;
      vel_left_q  <= vel_left_d;
      vel_up_q    <= vel_up_d;
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: design/visual_target_follow_controller_top.sv
`timescale 1ns / 1ps

// Visual target follow controller.
// The input channel (in_valid_i, in_stall_o, in_data_i) takes two kinds of
// word: detection frames, which update the body-frame target position and the
// hit and miss runs, and control ticks. A tick with command_mode_on set steps
// the waiting / tracking / lost mode machine and produces one result word on
// the output channel (out_valid_o, out_stall_i, out_data_o); other words
// produce none.
// A word is processed while it sits in the input register, and its result is
// loaded into the result register, from which it is offered.
// One word per cycle is taken when the output is not stalled; the rate is set
// by the single processing step between the input and result registers.
// When the receiver stalls, the result register holds its word. Detection
// frames keep flowing. A tick in command mode waits in the input register
// until the result register is free, which then stalls the input.
// Reset clears the tracking state, sets the sequence id to one and loads the
// configuration registers with their defaults. The user writes configuration via
// cfg_we_i, cfg_index_i and cfg_data_i while the block is idle; it is not enforced.
module visual_target_follow_controller_top import vtf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  vtf_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output vtf_out_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  vtf_cfg_t cfg;
  logic     in_valid_q, in_valid_d;
  vtf_in_t  in_q;
  logic     core_take;
  logic     in_accept;

  vtf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Input register: refilled in the same cycle the core takes its word.
  assign in_stall_o = in_valid_q && !core_take;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (core_take) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  vtf_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (in_valid_q),
    .item_i       (in_q),
    .item_take_o  (core_take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

// File: tb/visual_target_follow_controller_top_test.sv
`timescale 1ns / 1ps

module visual_target_follow_controller_top_test;
  import vtf_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 120;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PRINT_LIMIT  = 100;

  // Ways an episode ends its tracking stretch.
  typedef enum int {
    LOSS_DESELECT,
    LOSS_MISSES,
    LOSS_NOISE,
    LOSS_ANY
  } loss_kind_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  vtf_in_t     in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  vtf_out_t    out_word;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Shared control between the stimulus, the receiver and the checker.
  logic        idle_en = 1'b1;
  logic        hold_req = 1'b0;
  int          hold_left = 0;
  int          burst_left = 0;
  int          err_cnt = 0;
  int          results_seen = 0;
  int          words_sent = 0;
  int unsigned cycle_cnt = 0;

  // Predicted state of the follow controller.
  vtf_cfg_t           follow_cfg;
  vtf_phase_e         mode_ph;
  int                 pos_fwd, pos_left, pos_up;
  logic               conf_hit, sel_hold, seen;
  int                 hit_run, miss_run, lost_cnt;
  vtf_cmd_e           held_cmd;
  logic signed [15:0] held_vel [3];
  logic [31:0]        seq_id;
  vtf_out_t           cmd_expect_q [$];

  visual_target_follow_controller_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  // Proportional velocity with rounding half away from zero and saturation.
  function automatic logic signed [15:0] prop_velocity(longint pos, longint gain);
    longint mag;
    mag = (pos < 0) ? -pos : pos;
    mag = (mag * gain + (longint'(1) << (GAIN_FRAC_BITS - 1))) >>> GAIN_FRAC_BITS;
    if (pos < 0) return (mag > 32768) ? 16'sh8000 : 16'(-mag);
    return (mag > 32767) ? 16'sh7fff : 16'(mag);
  endfunction

  function automatic vtf_cfg_t default_settings();
    vtf_cfg_t s;
    s.gain_x        = 16'd2458;
    s.gain_y        = 16'd2458;
    s.gain_z        = 16'd1229;
    s.offset_x      = '0;
    s.offset_y      = '0;
    s.offset_z      = '0;
    s.hold_height   = 16'sd1500;
    s.run_threshold = 8'd10;
    return s;
  endfunction

  function automatic void reset_follow_model();
    follow_cfg = default_settings();
    mode_ph    = PH_WAIT;
    pos_fwd    = 0;
    pos_left   = 0;
    pos_up     = 0;
    conf_hit   = 1'b0;
    sel_hold   = 1'b0;
    seen       = 1'b0;
    hit_run    = 0;
    miss_run   = 0;
    lost_cnt   = 0;
    held_cmd   = CMD_HOVER_INIT;
    held_vel   = '{default: '0};
    seq_id     = 32'd1;
  endfunction

  // Apply one accepted word to the predicted state; ticks in command mode
  // push the command word they produce.
  function automatic void advance_follow_state(vtf_in_t w);
    vtf_out_t res;
    if (w.func == FUNC_DETECT) begin
      if (w.has_target) begin
        pos_fwd  = int'(follow_cfg.offset_x) - int'(w.cam_down);
        pos_left = int'(follow_cfg.offset_y) - int'(w.cam_right);
        pos_up   = int'(follow_cfg.offset_z) - int'(w.cam_ahead);
        conf_hit = (w.confidence != 16'd0);
        sel_hold = w.selected;
      end
      if (conf_hit) begin
        miss_run = 0;
        if (hit_run < 255) hit_run++;
      end else begin
        hit_run = 0;
        if (miss_run < 255) miss_run++;
      end
      if (miss_run > int'(follow_cfg.run_threshold)) seen = 1'b0;
      if (hit_run > int'(follow_cfg.run_threshold)) seen = 1'b1;
      return;
    end
    if (!w.command_mode_on) return;
    case (mode_ph)
      PH_TRACK: begin
        if (!sel_hold || !seen) begin
          mode_ph  = PH_LOST;
          lost_cnt = 0;
        end else begin
          held_cmd    = CMD_MOVE;
          held_vel[0] = prop_velocity(pos_fwd, follow_cfg.gain_x);
          held_vel[1] = prop_velocity(pos_left, follow_cfg.gain_y);
          held_vel[2] = prop_velocity(longint'(pos_up) + longint'(follow_cfg.hold_height),
                                      follow_cfg.gain_z);
        end
      end
      PH_LOST: begin
        if (lost_cnt < 31) lost_cnt++;
        held_cmd = (lost_cnt < LOST_HOVER_TICKS) ? CMD_HOVER_HERE : CMD_HOVER_INIT;
        if (sel_hold) mode_ph = PH_TRACK;
      end
      default: begin
        if (sel_hold && seen) mode_ph = PH_TRACK;
        else held_cmd = CMD_HOVER_INIT;
      end
    endcase
    seq_id             = seq_id + 32'd1;
    res.command        = held_cmd;
    res.vel_forward    = held_vel[0];
    res.vel_left       = held_vel[1];
    res.vel_up         = held_vel[2];
    res.command_number = seq_id;
    cmd_expect_q.push_back(res);
  endfunction

  // Random 16-bit value with the edges of the range weighted in.
  function automatic logic [15:0] rand_field16();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h8000;
      3: return 16'h7fff;
      4: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'($urandom_range(1, 8191));
      default: return 16'($urandom_range(500, 4500));
    endcase
  endfunction

  function automatic logic [15:0] rand_offset();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 1000) - 500);
    endcase
  endfunction

  function automatic vtf_cfg_t random_settings(logic [7:0] thr);
    vtf_cfg_t s;
    s.gain_x        = rand_gain();
    s.gain_y        = rand_gain();
    s.gain_z        = rand_gain();
    s.offset_x      = rand_offset();
    s.offset_y      = rand_offset();
    s.offset_z      = rand_offset();
    s.hold_height   = rand_offset();
    s.run_threshold = thr;
    return s;
  endfunction

  function automatic vtf_in_t detect_fields(logic has, logic signed [15:0] right,
                                            logic signed [15:0] down,
                                            logic signed [15:0] ahead,
                                            logic [15:0] conf, logic sel);
    vtf_in_t w;
    w.func            = FUNC_DETECT;
    w.has_target      = has;
    w.cam_right       = right;
    w.cam_down        = down;
    w.cam_ahead       = ahead;
    w.confidence      = conf;
    w.selected        = sel;
    w.command_mode_on = 1'($urandom);
    return w;
  endfunction

  function automatic vtf_in_t detect_word(logic has, logic hit, logic sel);
    logic [15:0] conf;
    conf = rand_field16();
    if (!hit) conf = 16'd0;
    else if (conf == 16'd0) conf = 16'($urandom_range(1, 65535));
    return detect_fields(has, rand_field16(), rand_field16(), rand_field16(), conf, sel);
  endfunction

  // Tick word; all fields but the word kind and the mode flag carry random content.
  function automatic vtf_in_t tick_word(logic on);
    vtf_in_t w;
    w                 = detect_fields(1'($urandom), rand_field16(), rand_field16(),
                                      rand_field16(), rand_field16(), 1'($urandom));
    w.func            = FUNC_TICK;
    w.command_mode_on = on;
    return w;
  endfunction

  function automatic vtf_in_t noise_word();
    vtf_in_t w;
    w      = tick_word(1'($urandom));
    w.func = 1'($urandom);
    return w;
  endfunction

  // Offer one word, wait until it is taken, then update the prediction.
  task automatic send_word(vtf_in_t w);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_follow_state(w);
    if (w.func == FUNC_DETECT || w.command_mode_on) words_sent++;
  endtask

  // Stop offering, let all expected commands arrive and the pipe empty.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (cmd_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(vtf_cfg_idx_e idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Write the full register set while the block is idle.
  task automatic apply_settings(vtf_cfg_t s);
    quiesce();
    cfg_write(CFG_GAIN_X, s.gain_x);
    cfg_write(CFG_GAIN_Y, s.gain_y);
    cfg_write(CFG_GAIN_Z, s.gain_z);
    cfg_write(CFG_OFFSET_X, s.offset_x);
    cfg_write(CFG_OFFSET_Y, s.offset_y);
    cfg_write(CFG_OFFSET_Z, s.offset_z);
    cfg_write(CFG_HOLD_HEIGHT, s.hold_height);
    cfg_write(CFG_RUN_THRESHOLD, 16'(s.run_threshold));
    cfg_we <= 1'b0;
    follow_cfg = s;
  endtask

  // One acquire, track, lose and linger sequence with random content.
  task automatic run_episode(int thr, loss_kind_e kind);
    int n;
    n = thr + 1 + $urandom_range(0, 3);
    send_word(detect_word(1'b1, 1'b1, 1'b1));
    repeat (n - 1) begin
      send_word(detect_word($urandom_range(0, 7) != 0, 1'b1, 1'b1));
      if ($urandom_range(0, 5) == 0) send_word(tick_word($urandom_range(0, 7) != 0));
    end
    repeat ($urandom_range(2, 10)) begin
      send_word(tick_word($urandom_range(0, 9) != 0));
      if ($urandom_range(0, 2) == 0) send_word(detect_word(1'b1, 1'b1, 1'b1));
    end
    if (kind == LOSS_ANY) kind = loss_kind_e'($urandom_range(0, 2));
    case (kind)
      LOSS_DESELECT: send_word(detect_word(1'b1, 1'b1, 1'b0));
      LOSS_MISSES: begin
        repeat (thr + 1 + $urandom_range(0, 2)) begin
          send_word(detect_word($urandom_range(0, 7) != 0, 1'b0, 1'($urandom)));
        end
        send_word(detect_word(1'b1, 1'b0, 1'b0));
      end
      default: repeat ($urandom_range(1, 6)) send_word(noise_word());
    endcase
    repeat ($urandom_range(0, 40)) begin
      send_word(tick_word($urandom_range(0, 9) != 0));
      if ($urandom_range(0, 9) == 0) send_word(noise_word());
    end
  endtask

  task automatic run_phase(vtf_cfg_t s, int budget, loss_kind_e kind);
    int stop_at;
    apply_settings(s);
    stop_at = words_sent + budget;
    while (words_sent < stop_at) run_episode(s.run_threshold, kind);
  endtask

  // Reset state: ignored tick, hover at start, frame without a target.
  task automatic test_startup();
    send_word(tick_word(1'b0));
    send_word(tick_word(1'b1));
    send_word(detect_fields(1'b0, 16'sh7fff, 16'sh8000, 16'sh0000, 16'hffff, 1'b1));
    send_word(tick_word(1'b1));
  endtask

  // Largest gains and extreme offsets drive the velocities into both limits.
  task automatic test_track_extremes();
    vtf_cfg_t s;
    s               = default_settings();
    s.gain_x        = 16'hffff;
    s.gain_y        = 16'hffff;
    s.gain_z        = 16'hffff;
    s.offset_x      = 16'sh7fff;
    s.offset_y      = 16'sh7fff;
    s.offset_z      = 16'sh7fff;
    s.hold_height   = 16'sh7fff;
    s.run_threshold = 8'd0;
    apply_settings(s);
    send_word(detect_fields(1'b1, 16'sh8000, 16'sh8000, 16'sh8000, 16'h0001, 1'b1));
    send_word(tick_word(1'b1));
    send_word(tick_word(1'b1));
    send_word(detect_fields(1'b1, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff, 1'b1));
    send_word(tick_word(1'b1));
    s.offset_x    = 16'sh8000;
    s.offset_y    = 16'sh8000;
    s.offset_z    = 16'sh8000;
    s.hold_height = 16'sh8000;
    apply_settings(s);
    send_word(detect_fields(1'b1, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff, 1'b1));
    send_word(tick_word(1'b1));
  endtask

  // Exact halves round away from zero, just under a half rounds to zero.
  task automatic test_rounding();
    vtf_cfg_t s;
    s               = default_settings();
    s.gain_x        = 16'd1;
    s.gain_y        = 16'd1;
    s.gain_z        = 16'd1;
    s.hold_height   = 16'sd0;
    s.run_threshold = 8'd0;
    apply_settings(s);
    send_word(detect_fields(1'b1, 16'sd2048, -16'sd2048, 16'sd2047, 16'h0001, 1'b1));
    send_word(tick_word(1'b1));
  endtask

  // Loss of the target, hovering while lost, and return on reselection.
  task automatic test_lost_and_return();
    vtf_cfg_t s;
    s               = default_settings();
    s.run_threshold = 8'd0;
    apply_settings(s);
    send_word(detect_word(1'b1, 1'b1, 1'b1));
    send_word(tick_word(1'b1));
    send_word(detect_word(1'b1, 1'b0, 1'b1));
    send_word(tick_word(1'b1));
    send_word(detect_word(1'b1, 1'b0, 1'b0));
    send_word(detect_word(1'b0, 1'b1, 1'b1));
    send_word(tick_word(1'b1));
    send_word(tick_word(1'b1));
    send_word(detect_word(1'b1, 1'b1, 1'b1));
    send_word(tick_word(1'b1));
    send_word(tick_word(1'b1));
  endtask

  task automatic test_random_mixed();
    run_phase(random_settings(8'($urandom_range(0, 12))), 180, LOSS_ANY);
    run_phase(random_settings(8'd0), 180, LOSS_ANY);
    run_phase(random_settings(8'($urandom_range(1, 12))), 180, LOSS_ANY);
  endtask

  // Highest threshold that can still trip: runs have to saturate before seen or lost is declared.
  task automatic test_long_runs();
    vtf_cfg_t s;
    s = random_settings(8'd254);
    apply_settings(s);
    run_episode(254, LOSS_MISSES);
  endtask

  // The receiver holds off for a long stretch while words keep coming.
  task automatic test_backpressure();
    run_phase(random_settings(8'($urandom_range(0, 4))), 0, LOSS_ANY);
    hold_req <= 1'b1;
    run_phase(follow_cfg, 200, LOSS_ANY);
  endtask

  task automatic test_no_idle();
    quiesce();
    idle_en = 1'b0;
    run_phase(random_settings(8'($urandom_range(0, 6))), 200, LOSS_ANY);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    err_cnt++;
    if (err_cnt <= PRINT_LIMIT) begin
      $display("mismatch on %s of command word %0d: got %0d, expected %0d",
               what, results_seen, got, want);
    end
  endtask

  // Receiver: random stall bursts, plus one long hold on request.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (burst_left != 0) begin
      burst_left <= burst_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      burst_left <= $urandom_range(0, 6);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted command word with the oldest prediction.
  always @(posedge clk) begin
    vtf_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (cmd_expect_q.size() == 0) begin
        report_mismatch("unexpected word, command number", out_word.command_number, 0);
      end else begin
        want = cmd_expect_q.pop_front();
        if (out_word.command !== want.command)
          report_mismatch("command", out_word.command, want.command);
        if (out_word.vel_forward !== want.vel_forward)
          report_mismatch("vel_forward", out_word.vel_forward, want.vel_forward);
        if (out_word.vel_left !== want.vel_left)
          report_mismatch("vel_left", out_word.vel_left, want.vel_left);
        if (out_word.vel_up !== want.vel_up)
          report_mismatch("vel_up", out_word.vel_up, want.vel_up);
        if (out_word.command_number !== want.command_number)
          report_mismatch("command_number", out_word.command_number,
                          want.command_number);
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("visual_target_follow_controller_top_test: done, errors");
    $finish;
  end

  initial begin
    reset_follow_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_startup();
    test_track_extremes();
    test_rounding();
    test_lost_and_return();
    test_random_mixed();
    test_long_runs();
    test_backpressure();
    test_no_idle();
    quiesce();
    if (err_cnt == 0) begin
      $display("visual_target_follow_controller_top_test: done, clean");
    end else begin
      $display("visual_target_follow_controller_top_test: done, errors");
    end
    $finish;
  end

endmodule
